// File: hw/rtl/gfrm_pkg.sv
// shared types and constants for the grid frequency rocof monitor
package gfrm_pkg;

    localparam int SAMPLE_RATE_HZ_DEF = 16000;

    localparam int COUNT_W = 16;
    localparam int FREQ_W  = 30;
    localparam int RATE_W  = 30;
    localparam int RTHR_W  = 25;
    localparam int CIDX_W  = 2;
    localparam int DIV_W   = 32;
    localparam int DREM_W  = 31;
    localparam int STEP_W  = 6;
    localparam int PROD_W  = 2 * FREQ_W;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FREQ_THR = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_RATE_THR = 2'd1;

    localparam logic [FREQ_W-1:0] FREQ_THR_RST = 30'd3244032;
    localparam logic [RTHR_W-1:0] RATE_THR_RST = 25'd655360;

    // +100 Hz/s ceiling and field floor magnitude, Q14.16
    localparam logic [RATE_W-1:0] RATE_TOP     = 30'd6553600;
    localparam logic [RATE_W-1:0] RATE_BOT_MAG = 30'h2000_0000;

    localparam logic [STEP_W-1:0] STEPS_FREQ = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_HARM = 6'd31;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DREM_W-1:0] rem_init;
        logic [DIV_W-1:0]  dividend;
        logic [DREM_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

// File: hw/rtl/grid_frequency_rocof_monitor.sv
// top level: period count to frequency and rate of change with stability flag
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  in       | i_in_valid / o_in_ready    | i_period_count
//  out      | o_out_valid / i_out_ready  | o_frequency, o_rate_of_change,
//           |                            | o_unstable, o_bad_count
//  cfg      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// a beat with a nonzero count runs the frequency divide (32 divider steps), the
// f * fprev multiply, the harmonic divide (31 steps, skipped when the sum is
// zero) and the rate multiply before the result is written; a zero count goes
// straight to the output register with the bad-count flag set.
// o_in_ready is high only while the sequencer is idle.
// the finished result waits in the output register; a stalled output holds
// the sequencer in its last state until the beat is taken.
// reset is synchronous: it clears control and the previous frequency and
// loads the default thresholds.
module grid_frequency_rocof_monitor #(
    parameter int SAMPLE_RATE_HZ = gfrm_pkg::SAMPLE_RATE_HZ_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input beat
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [gfrm_pkg::COUNT_W-1:0]       i_period_count,
    // result beat
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gfrm_pkg::FREQ_W-1:0]        o_frequency,
    output logic signed [gfrm_pkg::RATE_W-1:0] o_rate_of_change,
    output logic                               o_unstable,
    output logic                               o_bad_count,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [gfrm_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [gfrm_pkg::FREQ_W-1:0]        i_cfg_data
);

    // dividend for the frequency divide: rate shifted to Q.16
    localparam logic [gfrm_pkg::DIV_W-1:0] FREQ_NUM =
        gfrm_pkg::DIV_W'(SAMPLE_RATE_HZ) << 16;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV_F = 3'd1;
    localparam logic [2:0] S_MUL_P = 3'd2;
    localparam logic [2:0] S_HSTRT = 3'd3;
    localparam logic [2:0] S_DIV_H = 3'd4;
    localparam logic [2:0] S_MUL_R = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_BAD   = 3'd7;

    logic [2:0]                    r_state, n_state;

    // configuration
    logic [gfrm_pkg::FREQ_W-1:0]   r_fthr;
    logic [gfrm_pkg::RTHR_W-1:0]   r_rthr;

    // datapath
    logic [gfrm_pkg::FREQ_W-1:0]   r_prev;
    logic [gfrm_pkg::FREQ_W-1:0]   r_freq;
    logic [gfrm_pkg::DREM_W-1:0]   r_sum;
    logic [gfrm_pkg::FREQ_W-1:0]   r_mag;
    logic                          r_neg;
    logic [gfrm_pkg::FREQ_W-1:0]   r_harm;
    logic [gfrm_pkg::PROD_W-1:0]   r_prod;

    // result register
    logic                          r_out_valid;
    logic [gfrm_pkg::FREQ_W-1:0]   r_out_freq;
    logic [gfrm_pkg::RATE_W-1:0]   r_out_rate;
    logic                          r_out_unst;
    logic                          r_out_bad;

    gfrm_pkg::t_div_req            w_req;
    gfrm_pkg::t_div_rsp            w_rsp;

    logic                          w_in_acc;
    logic                          w_slot;
    logic [gfrm_pkg::FREQ_W-1:0]   w_fsat;
    logic [gfrm_pkg::FREQ_W-1:0]   w_mul_a;
    logic [gfrm_pkg::FREQ_W-1:0]   w_mul_b;
    logic [gfrm_pkg::PROD_W-1:0]   w_prod;
    logic [gfrm_pkg::PROD_W-17:0]  w_rmag_raw;
    logic [gfrm_pkg::RATE_W-1:0]   w_rmag;
    logic [gfrm_pkg::RATE_W-1:0]   w_rate;
    logic                          w_unst;

    assign w_in_acc = i_in_valid && o_in_ready;
    // output register free this cycle
    assign w_slot   = !r_out_valid || i_out_ready;

    // saturate the frequency quotient to 30 bits
    assign w_fsat = (w_rsp.quot[gfrm_pkg::DIV_W-1:gfrm_pkg::FREQ_W] != '0) ?
                    '1 : w_rsp.quot[gfrm_pkg::FREQ_W-1:0];

    // one shared multiplier: f * fprev, then |f - fprev| * h
    assign w_mul_a = (r_state == S_MUL_P) ? r_freq : r_mag;
    assign w_mul_b = (r_state == S_MUL_P) ? r_prev : r_harm;
    assign w_prod  = w_mul_a * w_mul_b;

    // rate magnitude after truncation and clamping
    assign w_rmag_raw = r_prod[gfrm_pkg::PROD_W-1:16];
    always_comb begin
        if (r_neg) begin
            w_rmag = (w_rmag_raw > (gfrm_pkg::PROD_W-16)'(gfrm_pkg::RATE_BOT_MAG)) ?
                     gfrm_pkg::RATE_BOT_MAG : w_rmag_raw[gfrm_pkg::RATE_W-1:0];
        end else begin
            w_rmag = (w_rmag_raw > (gfrm_pkg::PROD_W-16)'(gfrm_pkg::RATE_TOP)) ?
                     gfrm_pkg::RATE_TOP : w_rmag_raw[gfrm_pkg::RATE_W-1:0];
        end
    end
    assign w_rate = r_neg ? (~w_rmag + 1'b1) : w_rmag;
    assign w_unst = (r_freq < r_fthr) || (w_rmag > gfrm_pkg::RATE_W'(r_rthr));

    // divider requests
    always_comb begin
        w_req = '0;
        if (r_state == S_IDLE && w_in_acc && i_period_count != '0) begin
            w_req.start    = 1'b1;
            w_req.steps    = gfrm_pkg::STEPS_FREQ;
            w_req.rem_init = '0;
            w_req.dividend = FREQ_NUM;
            w_req.divisor  = gfrm_pkg::DREM_W'(i_period_count);
        end else if (r_state == S_HSTRT && r_sum != '0) begin
            // 2*f*p split: high bits preload the remainder, low bits shift in
            w_req.start    = 1'b1;
            w_req.steps    = gfrm_pkg::STEPS_HARM;
            w_req.rem_init = {1'b0, r_prod[gfrm_pkg::PROD_W-1:gfrm_pkg::FREQ_W]};
            w_req.dividend = {r_prod[gfrm_pkg::FREQ_W-1:0], 2'b00};
            w_req.divisor  = r_sum;
        end
    end

    gfrm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_period_count == '0) ? S_BAD : S_DIV_F;
                end
            end
            S_DIV_F: begin
                if (w_rsp.done) begin
                    n_state = S_MUL_P;
                end
            end
            S_MUL_P: n_state = S_HSTRT;
            S_HSTRT: n_state = (r_sum == '0) ? S_MUL_R : S_DIV_H;
            S_DIV_H: begin
                if (w_rsp.done) begin
                    n_state = S_MUL_R;
                end
            end
            S_MUL_R: n_state = S_FIN;
            S_FIN, S_BAD: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fthr      <= gfrm_pkg::FREQ_THR_RST;
            r_rthr      <= gfrm_pkg::RATE_THR_RST;
            r_prev      <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FIN || r_state == S_BAD) && w_slot) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && i_cfg_index == gfrm_pkg::CFG_FREQ_THR) begin
                r_fthr <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == gfrm_pkg::CFG_RATE_THR) begin
                r_rthr <= i_cfg_data[gfrm_pkg::RTHR_W-1:0];
            end
            // zero count leaves the previous frequency alone
            if (r_state == S_FIN && w_slot) begin
                r_prev <= r_freq;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV_F && w_rsp.done) begin
            r_freq <= w_fsat;
            r_sum  <= {1'b0, w_fsat} + {1'b0, r_prev};
            r_neg  <= w_fsat < r_prev;
            r_mag  <= (w_fsat < r_prev) ? (r_prev - w_fsat) : (w_fsat - r_prev);
        end
        if (r_state == S_HSTRT && r_sum == '0) begin
            r_harm <= '0;
        end else if (r_state == S_DIV_H && w_rsp.done) begin
            // harmonic term never exceeds the larger frequency
            r_harm <= w_rsp.quot[gfrm_pkg::FREQ_W-1:0];
        end
        if (r_state == S_MUL_P || r_state == S_MUL_R) begin
            r_prod <= w_prod;
        end
        if (r_state == S_FIN && w_slot) begin
            r_out_freq <= r_freq;
            r_out_rate <= w_rate;
            r_out_unst <= w_unst;
            r_out_bad  <= 1'b0;
        end else if (r_state == S_BAD && w_slot) begin
            r_out_freq <= '0;
            r_out_rate <= '0;
            r_out_unst <= 1'b0;
            r_out_bad  <= 1'b1;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_frequency      = r_out_freq;
    assign o_rate_of_change = r_out_rate;
    assign o_unstable       = r_out_unst;
    assign o_bad_count      = r_out_bad;

endmodule

// File: hw/rtl/gfrm_div.sv
// shared restoring divider, one quotient bit per cycle
module gfrm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gfrm_pkg::t_div_req  i_req,
    output gfrm_pkg::t_div_rsp  o_rsp
);

    logic [gfrm_pkg::DREM_W-1:0] r_rem,  n_rem;
    logic [gfrm_pkg::DIV_W-1:0]  r_q,    n_q;
    logic [gfrm_pkg::DREM_W-1:0] r_dsr;
    logic [gfrm_pkg::STEP_W-1:0] r_cnt,  n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;

    logic [gfrm_pkg::DIV_W-1:0]  w_shift;
    logic [gfrm_pkg::DIV_W-1:0]  w_diff;
    logic                        w_ge;

    assign w_shift = {r_rem, r_q[gfrm_pkg::DIV_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dsr};
    assign w_diff  = w_shift - {1'b0, r_dsr};

    always_comb begin
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem  = i_req.rem_init;
            n_q    = i_req.dividend;
            n_cnt  = i_req.steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // remainder stays below the divisor, so the top bit drops
            n_rem = w_ge ? w_diff[gfrm_pkg::DREM_W-1:0] : w_shift[gfrm_pkg::DREM_W-1:0];
            n_q   = {r_q[gfrm_pkg::DIV_W-2:0], w_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == gfrm_pkg::STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        if (i_req.start) begin
            r_dsr <= i_req.divisor;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// File: hw/rtl/gfrm_chk.sv
// port-level checks for the grid frequency rocof monitor, bound to the top level
module gfrm_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  logic [gfrm_pkg::FREQ_W-1:0]        o_frequency,
    input  logic signed [gfrm_pkg::RATE_W-1:0] o_rate_of_change,
    input  logic                               o_unstable,
    input  logic                               o_bad_count
);

    // zero count beat carries no measurement
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_count) |->
            (o_frequency == '0 && o_rate_of_change == '0 && !o_unstable))
        else $error("bad count beat carries nonzero fields");

    // rate never above the +100 Hz/s clamp
    a_rate_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_rate_of_change <= $signed({1'b0, gfrm_pkg::RATE_TOP[gfrm_pkg::RATE_W-2:0]})))
        else $error("rate above clamp");

    // a valid count always yields a nonzero frequency
    a_freq_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_bad_count) |-> (o_frequency != '0))
        else $error("zero frequency on a valid count");

    // block is busy right after taking a beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_frequency) && $stable(o_rate_of_change)))
        else $error("stalled result changed");

endmodule

bind grid_frequency_rocof_monitor gfrm_chk u_gfrm_chk (.*);

// File: tb/rocof_result_checker.sv
// checker for the rocof monitor: predicts each result beat and compares it field by field
`timescale 1ns / 100ps

module rocof_result_checker
    import gfrm_pkg::*;
#(
    parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [COUNT_W-1:0]        i_period_count,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [FREQ_W-1:0]         i_frequency,
    input  logic signed [RATE_W-1:0]  i_rate_of_change,
    input  logic                      i_unstable,
    input  logic                      i_bad_count,
    input  logic                      i_cfg_we,
    input  logic [CIDX_W-1:0]         i_cfg_index,
    input  logic [FREQ_W-1:0]         i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_flagged
);

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic [RATE_W-1:0] rate;
        logic              unstable;
        logic              bad_count;
    } t_rocof_result;

    t_rocof_result     expected_results[$];
    logic [FREQ_W-1:0] freq_limit = FREQ_THR_RST;
    logic [RTHR_W-1:0] rate_limit = RATE_THR_RST;
    logic [FREQ_W-1:0] last_freq  = '0;
    int                fail_count = 0;
    int                checked    = 0;
    int                flagged    = 0;
    int                pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_flagged    = flagged;

    // frequency, harmonic-mean rate and stability flag for one period count
    function automatic t_rocof_result predict_rocof(input logic [COUNT_W-1:0] cnt,
                                                    input logic [FREQ_W-1:0]  prev,
                                                    input logic [FREQ_W-1:0]  f_lim,
                                                    input logic [RTHR_W-1:0]  r_lim);
        t_rocof_result res;
        logic [63:0]   freq64;
        logic [63:0]   sum;
        logic [63:0]   harm;
        logic [63:0]   diff;
        logic [63:0]   mag;
        logic          falling;
        res = '0;
        if (cnt == '0) begin
            res.bad_count = 1'b1;
            return res;
        end
        freq64 = (64'(SAMPLE_RATE_HZ) << 16) / 64'(cnt);
        if (freq64 > 64'h3FFF_FFFF)
            freq64 = 64'h3FFF_FFFF;
        sum  = freq64 + 64'(prev);
        harm = (sum == 0) ? 64'd0 : (64'd2 * freq64 * 64'(prev)) / sum;
        falling = freq64 < 64'(prev);
        diff = falling ? 64'(prev) - freq64 : freq64 - 64'(prev);
        mag  = (diff * harm) >> 16;
        // clamp at +100 Hz/s going up, field floor going down
        if (falling) begin
            if (mag > 64'(RATE_BOT_MAG))
                mag = 64'(RATE_BOT_MAG);
        end else if (mag > 64'(RATE_TOP)) begin
            mag = 64'(RATE_TOP);
        end
        res.frequency = freq64[FREQ_W-1:0];
        res.rate      = falling ? -mag[RATE_W-1:0] : mag[RATE_W-1:0];
        res.unstable  = (freq64 < 64'(f_lim)) || (mag > 64'(r_lim));
        return res;
    endfunction

    task automatic check_field(input string what, input logic [RATE_W-1:0] want_v,
                               input logic [RATE_W-1:0] got_v);
        if (got_v !== want_v) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected 0x%h, got 0x%h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rocof_result want;
        if (!i_rst_n) begin
            freq_limit = FREQ_THR_RST;
            rate_limit = RATE_THR_RST;
            last_freq  = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FREQ_THR: freq_limit = i_cfg_data;
                    CFG_RATE_THR: rate_limit = i_cfg_data[RTHR_W-1:0];
                    default: ;
                endcase
            end
            // result beat first: it belongs to an earlier count than one taken this edge
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result beat with none expected, got freq 0x%h rate 0x%h",
                             $time, i_frequency, i_rate_of_change);
                end else begin
                    want = expected_results.pop_front();
                    check_field("frequency", RATE_W'(want.frequency), RATE_W'(i_frequency));
                    check_field("rate_of_change", want.rate, i_rate_of_change);
                    check_field("unstable", RATE_W'(want.unstable), RATE_W'(i_unstable));
                    check_field("bad_count", RATE_W'(want.bad_count), RATE_W'(i_bad_count));
                    checked++;
                    if (i_unstable)
                        flagged++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = predict_rocof(i_period_count, last_freq, freq_limit, rate_limit);
                if (!want.bad_count)
                    last_freq = want.frequency;
                expected_results.push_back(want);
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: tb/tb_grid_frequency_rocof_monitor.sv
// testbench top for the rocof monitor: stimulus, handshake pacing, threshold phases and verdict
`timescale 1ns / 100ps

module tb_grid_frequency_rocof_monitor;
    import gfrm_pkg::*;

    // register slots past the threshold pair; writes there must be ignored
    localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // long enough to cover one nonzero-count beat in flight
    localparam int LATENCY_CYCLES = 80;
    localparam int PHASES         = 6;
    localparam int BEATS_PER_PHASE = 100;

    logic                      i_clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [COUNT_W-1:0]        period_count;
    logic                      out_valid;
    logic                      out_ready;
    logic [FREQ_W-1:0]         frequency;
    logic signed [RATE_W-1:0]  rate_of_change;
    logic                      unstable;
    logic                      bad_count;
    logic                      cfg_we;
    logic [CIDX_W-1:0]         cfg_index;
    logic [FREQ_W-1:0]         cfg_data;

    int  fail_count;
    int  pending;
    int  checked;
    int  flagged;
    int  n_sent = 0;
    int  n_zero = 0;
    // when set, neither side idles or stalls
    bit  calm = 1'b0;

    // directed counts: zero before any update, nominal steps around 50 Hz, both
    // sides of the 49.5 Hz limit, a large step, the highest frequency with the
    // +100 Hz/s clamp, a drop deep enough to hit the negative floor, the lowest
    // frequency, a zero count after updates (state must hold), bit patterns
    logic [COUNT_W-1:0] directed_counts [0:19] = '{
        16'd0,     16'd320,   16'd320,   16'd321,   16'd319,
        16'd323,   16'd324,   16'd320,   16'd330,   16'd1,
        16'd1,     16'd2,     16'd65535, 16'd0,     16'd65535,
        16'hAAAA,  16'h5555,  16'h8000,  16'h7FFF,  16'd320
    };

    grid_frequency_rocof_monitor dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_period_count   (period_count),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_frequency      (frequency),
        .o_rate_of_change (rate_of_change),
        .o_unstable       (unstable),
        .o_bad_count      (bad_count),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    rocof_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_period_count   (period_count),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_frequency      (frequency),
        .i_rate_of_change (rate_of_change),
        .i_unstable       (unstable),
        .i_bad_count      (bad_count),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_flagged        (flagged)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // one count beat: idle gap, then hold valid and payload until taken
    task automatic send_count(input logic [COUNT_W-1:0] cnt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid     = 1'b1;
        period_count = cnt;
        do @(posedge i_clk); while (!in_ready);
        n_sent++;
        if (cnt == '0)
            n_zero++;
    endtask

    // stop sending, let every expected beat come back, then let the block go quiet
    task automatic settle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [FREQ_W-1:0] data);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    // mostly counts near a 50 Hz mains cycle, with wide swings, full range, very small counts and zeros
    function automatic logic [COUNT_W-1:0] draw_count();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return COUNT_W'($urandom_range(290, 360));
        else if (sel < 80)
            return COUNT_W'($urandom_range(100, 2000));
        else if (sel < 92)
            return COUNT_W'($urandom);
        else if (sel < 96)
            return COUNT_W'($urandom_range(1, 16));
        else
            return '0;
    endfunction

    // result side: random stall before each beat, ready held until it is taken
    initial begin : result_side
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            @(negedge i_clk);
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready = 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    initial begin : stimulus
        int phase;
        int k;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        period_count = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_FREQ_THR;
        cfg_data     = '0;
        repeat (7) @(negedge i_clk);
        rst_n = 1'b1;

        // directed beats run on the reset thresholds
        for (k = 0; k < 20; k++)
            send_count(directed_counts[k]);

        for (phase = 1; phase <= PHASES; phase++) begin
            settle();
            case (phase)
                1: begin
                    // everything with any rate flags
                    write_reg(CFG_FREQ_THR, '0);
                    write_reg(CFG_RATE_THR, '0);
                end
                2: begin
                    // all ones: rate register keeps only its low 25 bits
                    write_reg(CFG_FREQ_THR, 30'h3FFF_FFFF);
                    write_reg(CFG_RATE_THR, 30'h3FFF_FFFF);
                end
                3: begin
                    write_reg(CFG_FREQ_THR, FREQ_THR_RST);
                    write_reg(CFG_RATE_THR, FREQ_W'(RATE_THR_RST));
                    write_reg(CFG_SPARE_LO, FREQ_W'($urandom));
                end
                4: begin
                    // limits near the operating point: 48..52 Hz, 0..100 Hz/s
                    write_reg(CFG_FREQ_THR, FREQ_W'($urandom_range(48 << 16, 52 << 16)));
                    write_reg(CFG_RATE_THR, FREQ_W'($urandom_range(0, 100 << 16)));
                end
                5: begin
                    write_reg(CFG_FREQ_THR, FREQ_W'($urandom));
                    write_reg(CFG_RATE_THR, FREQ_W'($urandom));
                    write_reg(CFG_SPARE_HI, FREQ_W'($urandom));
                end
                default: begin
                    // top of the documented ranges
                    write_reg(CFG_FREQ_THR, 30'd1048576000);
                    write_reg(CFG_RATE_THR, 30'd16777216);
                end
            endcase
            for (k = 0; k < BEATS_PER_PHASE; k++) begin
                if (k % 25 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // hold off mid-phase until every result has come back
                if (phase == 2 && k == BEATS_PER_PHASE / 2)
                    settle();
                send_count(draw_count());
            end
        end

        settle();
        $display("sent %0d period counts (%0d zero) over %0d threshold settings",
                 n_sent, n_zero, PHASES + 1);
        $display("checked %0d result beats, %0d flagged unstable", checked, flagged);
        if (fail_count == 0)
            $display("grid_frequency_rocof_monitor verification clean");
        else
            $display("grid_frequency_rocof_monitor verification failed");
        $finish;
    end

    // a correct run needs about a millisecond; anything past this is a hang
    initial begin : watchdog
        #20_000_000;
        $display("grid_frequency_rocof_monitor verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/gfrm_pkg.sv
hw/rtl/gfrm_div.sv
hw/rtl/grid_frequency_rocof_monitor.sv
hw/rtl/gfrm_chk.sv
tb/rocof_result_checker.sv
tb/tb_grid_frequency_rocof_monitor.sv
